[design/msalne_pkg.sv]
package msalne_pkg;

   localparam int NUM_SEQS    = 4;
   localparam int SYMBOL_BITS = 5;
   localparam int NUM_PAIRS   = NUM_SEQS * (NUM_SEQS - 1) / 2;
   localparam int ADDR_BITS   = 2 * SYMBOL_BITS;
   localparam int TABLE_DEPTH = 2 ** ADDR_BITS;
   localparam int SCORE_BITS  = 11;
   localparam int COST_BITS   = 14;
   localparam int COST_MAX    = 2 ** (COST_BITS - 1) - 1;
   localparam int COST_MIN    = -(2 ** (COST_BITS - 1));
   localparam int SUM_NEED    = SCORE_BITS + $clog2(NUM_PAIRS) + 1;
   localparam int SUM_BITS    = (SUM_NEED > COST_BITS) ? SUM_NEED : COST_BITS + 1;

   localparam logic [SYMBOL_BITS-1:0] GAP_CODE = '1;

   // Request tdata layout, lowest field first.
   localparam int ROW_LSB      = 0;
   localparam int COL_LSB      = ROW_LSB + SYMBOL_BITS;
   localparam int SCORE_LSB    = COL_LSB + SYMBOL_BITS;
   localparam int SYMS_LSB     = SCORE_LSB + SCORE_BITS;
   localparam int EXH_LSB      = SYMS_LSB + NUM_SEQS * SYMBOL_BITS;
   localparam int REQ_USED     = EXH_LSB + NUM_SEQS;
   localparam int REQ_DATA_BITS = ((REQ_USED + 7) / 8) * 8;

   // Response tdata layout, lowest field first.
   localparam int RSP_COST_LSB  = NUM_SEQS;
   localparam int RSP_USED      = RSP_COST_LSB + COST_BITS;
   localparam int RSP_DATA_BITS = ((RSP_USED + 7) / 8) * 8;

   typedef enum logic {
      ACTION_LOAD   = 1'b0,
      ACTION_EXPAND = 1'b1
   } action_type;

   typedef logic [NUM_SEQS-1:0] seq_mask_type;

   typedef struct packed {
      logic         valid;
      seq_mask_type edge_mask;
      logic         last;
   } stage_type;

   // Sequence pairs are numbered in the order (0,1), (0,2), ..., (1,2), ...
   function automatic int pair_row(input int p);
      int cnt;
      int res;
      cnt = 0;
      res = 0;
      for (int i = 0; i < NUM_SEQS; i++) begin
         for (int j = i + 1; j < NUM_SEQS; j++) begin
            if (cnt == p) begin
               res = i;
            end
            cnt++;
         end
      end
      return res;
   endfunction

   function automatic int pair_col(input int p);
      int cnt;
      int res;
      cnt = 0;
      res = 0;
      for (int i = 0; i < NUM_SEQS; i++) begin
         for (int j = i + 1; j < NUM_SEQS; j++) begin
            if (cnt == p) begin
               res = j;
            end
            cnt++;
         end
      end
      return res;
   endfunction

endpackage

[design/msalne_lane.sv]
module msalne_lane (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [msalne_pkg::ADDR_BITS-1:0]      wr_addr,
   input  logic [msalne_pkg::SCORE_BITS-1:0]     wr_data,
   input  logic                                  rd_en,
   input  logic [msalne_pkg::ADDR_BITS-1:0]      rd_addr,
   output logic [msalne_pkg::SCORE_BITS-1:0]     rd_data
);

   // Each lane keeps a full copy of the score table so that all pairs of a
   // column are looked up in the same cycle.
   logic [msalne_pkg::SCORE_BITS-1:0] score_mem_ff [msalne_pkg::TABLE_DEPTH];
   logic [msalne_pkg::SCORE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         score_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= score_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/msalne_merge.sv]
module msalne_merge (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  advance,
   input  msalne_pkg::stage_type                                 stage,
   input  logic [msalne_pkg::NUM_PAIRS-1:0][msalne_pkg::SCORE_BITS-1:0] scores,
   output logic                                                  out_valid,
   output msalne_pkg::seq_mask_type                              out_edge_mask,
   output logic [msalne_pkg::COST_BITS-1:0]                      out_cost,
   output logic                                                  out_last
);

   localparam logic signed [msalne_pkg::SUM_BITS-1:0] SAT_HI =
      msalne_pkg::SUM_BITS'(msalne_pkg::COST_MAX);
   localparam logic signed [msalne_pkg::SUM_BITS-1:0] SAT_LO =
      msalne_pkg::SUM_BITS'(msalne_pkg::COST_MIN);

   logic                                 valid_ff;
   logic                                 valid_in;
   msalne_pkg::seq_mask_type             edge_mask_ff;
   logic                                 last_ff;
   logic [msalne_pkg::COST_BITS-1:0]     cost_ff;
   logic [msalne_pkg::COST_BITS-1:0]     cost_in;
   logic signed [msalne_pkg::SUM_BITS-1:0] sum;

   always_comb begin
      sum = '0;
      for (int p = 0; p < msalne_pkg::NUM_PAIRS; p++) begin
         sum = sum + {{(msalne_pkg::SUM_BITS - msalne_pkg::SCORE_BITS)
                       {scores[p][msalne_pkg::SCORE_BITS-1]}}, scores[p]};
      end
      priority if (sum > SAT_HI) begin
         cost_in = SAT_HI[msalne_pkg::COST_BITS-1:0];
      end else if (sum < SAT_LO) begin
         cost_in = SAT_LO[msalne_pkg::COST_BITS-1:0];
      end else begin
         cost_in = sum[msalne_pkg::COST_BITS-1:0];
      end
   end

   assign valid_in = advance ? stage.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         edge_mask_ff <= stage.edge_mask;
         last_ff      <= stage.last;
         cost_ff      <= cost_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_edge_mask = edge_mask_ff;
   assign out_cost      = cost_ff;
   assign out_last      = last_ff;

endmodule

[design/msa_lattice_node_expander.sv]
// Load item: the score entry is written at the accepting edge.
// Expand item with k live sequences: 2^k-1 successors, one per cycle while
// the output is not held, in ascending edge mask order, set by the subset
// sequencer driving one lookup per sequence pair in parallel table copies.
// The first successor passes the sequencer, lookup and merge registers; the
// next item is taken once the last successor has been issued. Reset clears
// the control state only; the score table holds whatever it had until written.
module msa_lattice_node_expander (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // row_symbol, col_symbol, score_value, next_symbols, exhausted_mask, zero pad
   input  logic [msalne_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // action
   input  logic [0:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // edge_mask, cost, zero pad
   output logic [msalne_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int NS = msalne_pkg::NUM_SEQS;
   localparam int SB = msalne_pkg::SYMBOL_BITS;

   logic                               busy_ff, busy_in;
   msalne_pkg::seq_mask_type           edge_ff, edge_in;
   msalne_pkg::seq_mask_type           live_ff, live_in;
   logic [NS-1:0][SB-1:0]              syms_ff, syms_in;
   msalne_pkg::stage_type              st1_ff, st1_in;

   logic                               accept;
   logic                               do_load;
   logic                               do_expand;
   logic                               advance;
   logic                               issue;
   logic                               issue_last;
   msalne_pkg::seq_mask_type           req_live;
   msalne_pkg::seq_mask_type           next_edge;
   logic [NS-1:0][SB-1:0]              col_sym;
   logic [msalne_pkg::ADDR_BITS-1:0]   wr_addr;
   logic [msalne_pkg::NUM_PAIRS-1:0][msalne_pkg::SCORE_BITS-1:0] scores;
   msalne_pkg::seq_mask_type           out_edge_mask;
   logic [msalne_pkg::COST_BITS-1:0]   out_cost;

   assign req_tready = ~busy_ff;
   assign accept     = req_tvalid & req_tready;
   assign do_load    = accept & (req_tuser == msalne_pkg::ACTION_LOAD);
   assign do_expand  = accept & (req_tuser == msalne_pkg::ACTION_EXPAND);
   assign req_live   = ~req_tdata[msalne_pkg::EXH_LSB +: NS];

   // The whole result pipeline stalls together while the output is held.
   assign advance    = ~rsp_tvalid | rsp_tready;
   assign issue      = busy_ff & advance;
   assign issue_last = (edge_ff == live_ff);

   // Next larger subset of the live mask.
   assign next_edge = ((edge_ff | ~live_ff) + NS'(1)) & live_ff;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         col_sym[i] = edge_ff[i] ? syms_ff[i] : msalne_pkg::GAP_CODE;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      edge_in = edge_ff;
      live_in = live_ff;
      syms_in = syms_ff;
      if (do_expand && (req_live != '0)) begin
         busy_in = 1'b1;
         live_in = req_live;
         edge_in = req_live & (~req_live + NS'(1));
         syms_in = req_tdata[msalne_pkg::SYMS_LSB +: NS * SB];
      end else if (issue) begin
         busy_in = ~issue_last;
         edge_in = next_edge;
      end
   end

   always_comb begin
      st1_in = st1_ff;
      if (advance) begin
         st1_in.valid     = issue;
         st1_in.edge_mask = edge_ff;
         st1_in.last      = issue_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         st1_ff.valid <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         st1_ff.valid <= st1_in.valid;
      end
      edge_ff          <= edge_in;
      live_ff          <= live_in;
      syms_ff          <= syms_in;
      st1_ff.edge_mask <= st1_in.edge_mask;
      st1_ff.last      <= st1_in.last;
   end

   assign wr_addr = {req_tdata[msalne_pkg::ROW_LSB +: SB], req_tdata[msalne_pkg::COL_LSB +: SB]};

   for (genvar p = 0; p < msalne_pkg::NUM_PAIRS; p++) begin : g_lane
      localparam int PR = msalne_pkg::pair_row(p);
      localparam int PC = msalne_pkg::pair_col(p);

      msalne_lane u_lane (
         .clock   (clock),
         .wr_en   (do_load),
         .wr_addr (wr_addr),
         .wr_data (req_tdata[msalne_pkg::SCORE_LSB +: msalne_pkg::SCORE_BITS]),
         .rd_en   (advance),
         .rd_addr ({col_sym[PR], col_sym[PC]}),
         .rd_data (scores[p])
      );
   end

   msalne_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .stage         (st1_ff),
      .scores        (scores),
      .out_valid     (rsp_tvalid),
      .out_edge_mask (out_edge_mask),
      .out_cost      (out_cost),
      .out_last      (rsp_tlast)
   );

   assign rsp_tdata = {(msalne_pkg::RSP_DATA_BITS - msalne_pkg::RSP_USED)'(0),
                       out_cost, out_edge_mask};

endmodule
